FILE: rtl/core/obb_pkg.sv
`timescale 1ns / 1ps
package obb_pkg;

  localparam int NUM_LANES   = 4;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 5;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_C0_X = 3'd0,
    REG_C0_Y = 3'd1,
    REG_C1_X = 3'd2,
    REG_C1_Y = 3'd3,
    REG_C2_X = 3'd4,
    REG_C2_Y = 3'd5,
    REG_C3_X = 3'd6,
    REG_C3_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic sep;
    logic deg;
  } lane_res_t;

endpackage

FILE: rtl/core/obb_lane.sv
`timescale 1ns / 1ps
module obb_lane #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] a_x0,
  input  logic signed [W-1:0] a_y0,
  input  logic signed [W-1:0] a_xk,
  input  logic signed [W-1:0] a_yk,
  input  logic signed [W-1:0] b_x [obb_pkg::NUM_CORNERS],
  input  logic signed [W-1:0] b_y [obb_pkg::NUM_CORNERS],
  output obb_pkg::lane_res_t  res
);

  localparam int EW = W + 1;
  localparam int PW = 2 * W + 1;
  localparam int DW = 2 * W + 3;

  logic                 s1_valid;
  logic signed [EW-1:0] s1_ex;
  logic signed [EW-1:0] s1_ey;
  logic signed [W-1:0]  s1_ax;
  logic signed [W-1:0]  s1_ay;
  logic signed [W-1:0]  s1_bx [obb_pkg::NUM_CORNERS];
  logic signed [W-1:0]  s1_by [obb_pkg::NUM_CORNERS];

  logic                 s2_valid;
  logic                 s2_deg;
  logic signed [PW-1:0] s2_pbx [obb_pkg::NUM_CORNERS];
  logic signed [PW-1:0] s2_pby [obb_pkg::NUM_CORNERS];
  logic signed [PW-1:0] s2_pax;
  logic signed [PW-1:0] s2_pay;
  logic signed [PW-1:0] s2_pex;
  logic signed [PW-1:0] s2_pey;

  logic                 s3_valid;
  logic                 s3_deg;
  logic signed [DW-1:0] s3_t [obb_pkg::NUM_CORNERS];
  logic signed [DW-1:0] s3_lo;
  logic signed [DW-1:0] s3_ee;

  logic                 s4_valid;
  logic                 s4_deg;
  logic signed [DW-1:0] s4_lo;
  logic signed [DW-1:0] s4_hi;
  logic signed [DW-1:0] s4_tmin;
  logic signed [DW-1:0] s4_tmax;

  logic signed [DW-1:0] min01;
  logic signed [DW-1:0] min23;
  logic signed [DW-1:0] max01;
  logic signed [DW-1:0] max23;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_ex <= EW'(a_xk) - EW'(a_x0);
    s1_ey <= EW'(a_yk) - EW'(a_y0);
    s1_ax <= a_x0;
    s1_ay <= a_y0;
    s1_bx <= b_x;
    s1_by <= b_y;
  end

  always_ff @(posedge clk) begin
    s2_deg <= (s1_ex == '0) && (s1_ey == '0);
    for (int c = 0; c < obb_pkg::NUM_CORNERS; c++) begin
      s2_pbx[c] <= PW'(s1_bx[c]) * PW'(s1_ex);
      s2_pby[c] <= PW'(s1_by[c]) * PW'(s1_ey);
    end
    s2_pax <= PW'(s1_ax) * PW'(s1_ex);
    s2_pay <= PW'(s1_ay) * PW'(s1_ey);
    s2_pex <= PW'(s1_ex) * PW'(s1_ex);
    s2_pey <= PW'(s1_ey) * PW'(s1_ey);
  end

  always_ff @(posedge clk) begin
    s3_deg <= s2_deg;
    for (int c = 0; c < obb_pkg::NUM_CORNERS; c++) begin
      s3_t[c] <= DW'(s2_pbx[c]) + DW'(s2_pby[c]);
    end
    s3_lo <= DW'(s2_pax) + DW'(s2_pay);
    s3_ee <= DW'(s2_pex) + DW'(s2_pey);
  end

  always_comb begin
    min01 = (s3_t[1] < s3_t[0]) ? s3_t[1] : s3_t[0];
    min23 = (s3_t[3] < s3_t[2]) ? s3_t[3] : s3_t[2];
    max01 = (s3_t[0] < s3_t[1]) ? s3_t[1] : s3_t[0];
    max23 = (s3_t[2] < s3_t[3]) ? s3_t[3] : s3_t[2];
  end

  always_ff @(posedge clk) begin
    s4_deg  <= s3_deg;
    s4_lo   <= s3_lo;
    s4_hi   <= s3_lo + s3_ee;
    s4_tmin <= (min23 < min01) ? min23 : min01;
    s4_tmax <= (max01 < max23) ? max23 : max01;
  end

  always_ff @(posedge clk) begin
    res.deg <= s4_deg;
    res.sep <= (s4_hi < s4_tmin) || (s4_tmax < s4_lo);
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s4_valid;
    end
  end

endmodule

FILE: rtl/core/obb_merge.sv
`timescale 1ns / 1ps
module obb_merge (
  input  logic               clk,
  input  logic               rst,
  input  obb_pkg::lane_res_t lanes [obb_pkg::NUM_LANES],
  output logic               done,
  output logic               overlap,
  output logic               degenerate
);

  logic [obb_pkg::NUM_LANES-1:0] valid_vec;
  logic                          any_sep;
  logic                          any_deg;

  always_comb begin
    any_sep = 1'b0;
    any_deg = 1'b0;
    for (int i = 0; i < obb_pkg::NUM_LANES; i++) begin
      valid_vec[i] = lanes[i].valid;
      any_sep      = any_sep | lanes[i].sep;
      any_deg      = any_deg | lanes[i].deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lanes[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    overlap    <= ~any_sep;
    degenerate <= any_deg;
  end

  // All lanes are fed by the same request, so their valid bits move in step.
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (valid_vec == '0) || (valid_vec == '1))
    else $error("lane valid bits out of step");

endmodule

FILE: rtl/core/obb2d_overlap_test.sv
`timescale 1ns / 1ps
// Channel   Signals                                  Direction  Handshake
// request   start, busy, box_c0_x .. box_c3_y        in         start & !busy
// result    done, overlap, degenerate                out        done, one cycle
// config    psel, penable, pwrite, paddr, pwdata,    in/out     APB, pready high
//           prdata, pready
//
// One request is taken every cycle; busy is never raised.
// The result is registered through the four axis lanes (edge, multiply,
// dot sum, min/max, compare) and the merging register.
// Reset clears the pipeline valid bits and the reference corners to zero.
// The receiver cannot stall, so no result is ever held back.
module obb2d_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       box_c0_x,
  input  logic signed [COORD_WIDTH-1:0]       box_c0_y,
  input  logic signed [COORD_WIDTH-1:0]       box_c1_x,
  input  logic signed [COORD_WIDTH-1:0]       box_c1_y,
  input  logic signed [COORD_WIDTH-1:0]       box_c2_x,
  input  logic signed [COORD_WIDTH-1:0]       box_c2_y,
  input  logic signed [COORD_WIDTH-1:0]       box_c3_x,
  input  logic signed [COORD_WIDTH-1:0]       box_c3_y,
  output logic                                done,
  output logic                                overlap,
  output logic                                degenerate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [obb_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [obb_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [obb_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] ref_regs [obb_pkg::NUM_REGS];
  logic signed [W-1:0] ref_x [obb_pkg::NUM_CORNERS];
  logic signed [W-1:0] ref_y [obb_pkg::NUM_CORNERS];
  logic signed [W-1:0] box_x [obb_pkg::NUM_CORNERS];
  logic signed [W-1:0] box_y [obb_pkg::NUM_CORNERS];
  logic [obb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          accept;
  logic                          cfg_wr;
  obb_pkg::lane_res_t            lane_res [obb_pkg::NUM_LANES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign reg_idx = paddr[obb_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < obb_pkg::NUM_REGS; i++) begin
        ref_regs[i] <= '0;
      end
    end else if (cfg_wr) begin
      ref_regs[reg_idx] <= pwdata[W-1:0];
    end
  end

  assign prdata = obb_pkg::APB_DATA_W'(ref_regs[reg_idx]);

  assign ref_x[0] = ref_regs[obb_pkg::REG_C0_X];
  assign ref_y[0] = ref_regs[obb_pkg::REG_C0_Y];
  assign ref_x[1] = ref_regs[obb_pkg::REG_C1_X];
  assign ref_y[1] = ref_regs[obb_pkg::REG_C1_Y];
  assign ref_x[2] = ref_regs[obb_pkg::REG_C2_X];
  assign ref_y[2] = ref_regs[obb_pkg::REG_C2_Y];
  assign ref_x[3] = ref_regs[obb_pkg::REG_C3_X];
  assign ref_y[3] = ref_regs[obb_pkg::REG_C3_Y];

  assign box_x[0] = box_c0_x;
  assign box_y[0] = box_c0_y;
  assign box_x[1] = box_c1_x;
  assign box_y[1] = box_c1_y;
  assign box_x[2] = box_c2_x;
  assign box_y[2] = box_c2_y;
  assign box_x[3] = box_c3_x;
  assign box_y[3] = box_c3_y;

  // Lanes 0 and 1 test the axes of the reference box, lanes 2 and 3 those of
  // the requested box; each uses corner 1 or corner 3 as its edge end.
  for (genvar g = 0; g < obb_pkg::NUM_LANES; g++) begin : g_lane
    localparam int K = (g % 2 == 0) ? 1 : 3;
    if (g < 2) begin : g_ref_axis
      obb_lane #(.W(W)) u_lane (
        .clk      (clk),
        .rst      (rst),
        .in_valid (accept),
        .a_x0     (ref_x[0]),
        .a_y0     (ref_y[0]),
        .a_xk     (ref_x[K]),
        .a_yk     (ref_y[K]),
        .b_x      (box_x),
        .b_y      (box_y),
        .res      (lane_res[g])
      );
    end else begin : g_box_axis
      obb_lane #(.W(W)) u_lane (
        .clk      (clk),
        .rst      (rst),
        .in_valid (accept),
        .a_x0     (box_x[0]),
        .a_y0     (box_y[0]),
        .a_xk     (box_x[K]),
        .a_yk     (box_y[K]),
        .b_x      (ref_x),
        .b_y      (ref_y),
        .res      (lane_res[g])
      );
    end
  end

  obb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lanes      (lane_res),
    .done       (done),
    .overlap    (overlap),
    .degenerate (degenerate)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##5 done)
    else $error("accepted request gave no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ##5 !done)
    else $error("result without a request");

  a_lane_valid_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##4 lane_res[3].valid)
    else $error("lane pipeline lost a request");

endmodule

FILE: bench/obb2d_overlap_test_tb.sv
`timescale 1ns / 1ps
module obb2d_overlap_test_tb;

  localparam int COORD_W = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0][COORD_W-1:0] box_t;

  typedef struct packed {
    logic overlap;
    logic degenerate;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] box_c0_x = '0;
  logic signed [COORD_W-1:0] box_c0_y = '0;
  logic signed [COORD_W-1:0] box_c1_x = '0;
  logic signed [COORD_W-1:0] box_c1_y = '0;
  logic signed [COORD_W-1:0] box_c2_x = '0;
  logic signed [COORD_W-1:0] box_c2_y = '0;
  logic signed [COORD_W-1:0] box_c3_x = '0;
  logic signed [COORD_W-1:0] box_c3_y = '0;
  logic done;
  logic overlap;
  logic degenerate;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [obb_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [obb_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [obb_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  box_t pending_boxes[$];
  result_t expected_results[$];
  box_t ref_box = '0;
  box_t driven_box = '0;
  result_t oldest_result;
  int send_idle_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  obb2d_overlap_test #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .box_c0_x(box_c0_x),
    .box_c0_y(box_c0_y),
    .box_c1_x(box_c1_x),
    .box_c1_y(box_c1_y),
    .box_c2_x(box_c2_x),
    .box_c2_y(box_c2_y),
    .box_c3_x(box_c3_x),
    .box_c3_y(box_c3_y),
    .done(done),
    .overlap(overlap),
    .degenerate(degenerate),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint coord(box_t b, int i);
    return longint'($signed(b[i]));
  endfunction

  function automatic int mag(longint v);
    return int'(v < 0 ? -v : v);
  endfunction

  function automatic result_t predict_overlap(box_t ref_b, box_t test_b);
    box_t a;
    box_t b;
    longint ex, ey, lo, hi, t, tmin, tmax;
    result_t res;
    res.overlap = 1'b1;
    res.degenerate = 1'b0;
    for (int side = 0; side < 2; side++) begin
      a = (side == 0) ? ref_b : test_b;
      b = (side == 0) ? test_b : ref_b;
      for (int k = 1; k <= 3; k += 2) begin
        ex = coord(a, 2 * k) - coord(a, 0);
        ey = coord(a, 2 * k + 1) - coord(a, 1);
        if (ex == 0 && ey == 0) begin
          res.degenerate = 1'b1;
        end
        lo = coord(a, 0) * ex + coord(a, 1) * ey;
        hi = lo + ex * ex + ey * ey;
        tmin = coord(b, 0) * ex + coord(b, 1) * ey;
        tmax = tmin;
        for (int c = 1; c < 4; c++) begin
          t = coord(b, 2 * c) * ex + coord(b, 2 * c + 1) * ey;
          if (t < tmin) begin
            tmin = t;
          end
          if (t > tmax) begin
            tmax = t;
          end
        end
        if (hi < tmin || tmax < lo) begin
          res.overlap = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic box_t box_of(int x0, int y0, int x1, int y1,
                                  int x2, int y2, int x3, int y3);
    box_t b;
    b[0] = 16'(x0);
    b[1] = 16'(y0);
    b[2] = 16'(x1);
    b[3] = 16'(y1);
    b[4] = 16'(x2);
    b[5] = 16'(y2);
    b[6] = 16'(x3);
    b[7] = 16'(y3);
    return b;
  endfunction

  function automatic box_t rect_box(int x0, int y0, int dx, int dy, int r);
    int px, py;
    px = (-dy) >>> r;
    py = dx >>> r;
    return box_of(x0, y0, x0 + dx, y0 + dy, x0 + dx + px, y0 + dy + py, x0 + px, y0 + py);
  endfunction

  function automatic box_t random_box();
    int mode, span, dx, dy, r, spread, cx, cy;
    box_t b;
    mode = $urandom_range(0, 99);
    if (mode < 12) begin
      for (int i = 0; i < 8; i++) begin
        b[i] = 16'($urandom);
      end
      return b;
    end
    if (mode < 20) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 4))
          0: b[i] = 16'h8000;
          1: b[i] = 16'h7fff;
          2: b[i] = 16'h0000;
          3: b[i] = 16'hffff;
          default: b[i] = 16'($urandom);
        endcase
      end
      return b;
    end
    span = 1 << $urandom_range(2, 14);
    dx = int'($urandom_range(0, 2 * span)) - span;
    dy = int'($urandom_range(0, 2 * span)) - span;
    r = $urandom_range(0, 2);
    spread = span + (mag(coord(ref_box, 2) - coord(ref_box, 0)) +
                     mag(coord(ref_box, 3) - coord(ref_box, 1)) +
                     mag(coord(ref_box, 6) - coord(ref_box, 0)) +
                     mag(coord(ref_box, 7) - coord(ref_box, 1))) / 2;
    cx = int'((coord(ref_box, 0) + coord(ref_box, 4)) / 2) +
         int'($urandom_range(0, 2 * spread)) - spread;
    cy = int'((coord(ref_box, 1) + coord(ref_box, 5)) / 2) +
         int'($urandom_range(0, 2 * spread)) - spread;
    b = rect_box(cx - dx / 2, cy - dy / 2, dx, dy, r);
    if (mode < 28) begin
      if ($urandom_range(0, 1) == 1) begin
        {b[2], b[3]} = {b[0], b[1]};
      end else begin
        {b[6], b[7]} = {b[0], b[1]};
      end
    end else if (mode < 34) begin
      b[4] = b[4] + 16'($urandom_range(0, 4000)) - 16'd2000;
      b[5] = b[5] + 16'($urandom_range(0, 4000)) - 16'd2000;
    end
    return b;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    if (mismatches < 50) begin
      $display("MISMATCH cycle %0d: %s got %b expected %b", cycle_count, what, got, want);
    end
    mismatches++;
  endtask

  task automatic apb_write(obb_pkg::reg_idx_t idx, logic [COORD_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ref_box[idx] = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_reference(box_t cfg);
    for (int i = 0; i < obb_pkg::NUM_REGS; i++) begin
      apb_write(obb_pkg::reg_idx_t'(i), cfg[i]);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_boxes.size() == 0 && !start && expected_results.size() == 0));
  endtask

  task automatic run_phase(box_t cfg, int idle_pct, int count);
    wait_idle();
    repeat (8) @(posedge clk);
    set_reference(cfg);
    @(negedge clk);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_idle();
      end
      pending_boxes.push_back(random_box());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_overlap(ref_box, driven_box));
      end
      if (!start || !busy) begin
        if (pending_boxes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_box = pending_boxes.pop_front();
          box_c0_x <= driven_box[0];
          box_c0_y <= driven_box[1];
          box_c1_x <= driven_box[2];
          box_c1_y <= driven_box[3];
          box_c2_x <= driven_box[4];
          box_c2_y <= driven_box[5];
          box_c3_x <= driven_box[6];
          box_c3_y <= driven_box[7];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, overlap", overlap, 1'bx);
      end else begin
        oldest_result = expected_results.pop_front();
        if (overlap !== oldest_result.overlap) begin
          report_mismatch("overlap", overlap, oldest_result.overlap);
        end
        if (degenerate !== oldest_result.degenerate) begin
          report_mismatch("degenerate", degenerate, oldest_result.degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reference box is all zeros after reset, so only the tested box axes count.
    pending_boxes.push_back(box_of(0, 0, 0, 0, 0, 0, 0, 0));
    pending_boxes.push_back(box_of(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000));
    pending_boxes.push_back(box_of(100, 100, 200, 100, 200, 200, 100, 200));
    wait_idle();
    repeat (8) @(posedge clk);
    set_reference(box_of(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000));
    @(negedge clk);
    pending_boxes.push_back(box_of(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000));
    pending_boxes.push_back(box_of(5000, 5000, 6000, 5000, 6000, 6000, 5000, 6000));
    pending_boxes.push_back(box_of(1000, -1000, 3000, -1000, 3000, 1000, 1000, 1000));
    pending_boxes.push_back(box_of(1001, -1000, 3000, -1000, 3000, 1000, 1001, 1000));
    pending_boxes.push_back(box_of(-32768, -32768, 32767, -32768, 32767, 32767,
                                   -32768, 32767));
    pending_boxes.push_back(box_of(-32768, -32768, -32768, -32768, -32768, -32768,
                                   -32768, -32768));
    pending_boxes.push_back(box_of(32767, 32767, 32767, 32767, 32767, 32767,
                                   32767, 32767));
    pending_boxes.push_back(box_of(0, 0, 0, 0, 500, 500, 0, 500));
    pending_boxes.push_back(box_of(0, 0, 500, 0, 500, 500, 0, 0));
    pending_boxes.push_back(box_of(900, 1400, 1400, 900, 1900, 1400, 1400, 1900));
    // A diamond beyond the corner: the bounding boxes meet, but its own edge separates.
    pending_boxes.push_back(box_of(900, 1400, 1400, 900, 1900, 1400, 1400, 1900));
    pending_boxes.push_back(box_of(1000, 1500, 1500, 1000, 2000, 1500, 1500, 2000));
    pending_boxes.push_back(box_of(-3000, -3000, -2000, -3000, 30000, 30000, -3000, -2000));
    pending_boxes.push_back(box_of(16'h5555, 16'haaaa, 16'h5555, 16'h5555,
                                   16'haaaa, 16'haaaa, 16'haaaa, 16'h5555));
    pending_boxes.push_back(box_of(16'haaaa, 16'h5555, 16'haaaa, 16'haaaa,
                                   16'h5555, 16'h5555, 16'h5555, 16'haaaa));
    pending_boxes.push_back(box_of(-32768, 32767, 32767, -32768, 32767, 32767,
                                   -32768, -32768));
    pending_boxes.push_back(box_of(-1, -1, 1, -1, 1, 1, -1, 1));

    run_phase(box_of(-3000, 500, 1000, 3500, 100, 4700, -3900, 1700), 0, 180);
    run_phase(box_of(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767), 55, 140);
    run_phase(box_of(5, -3, 9, -1, 8, 1, 4, -1), 12, 140);
    run_phase(box_of(100, 100, 100, 100, 400, 400, -200, 500), 55, 140);
    run_phase(rect_box(int'($urandom_range(0, 20000)) - 10000,
                       int'($urandom_range(0, 20000)) - 10000,
                       int'($urandom_range(0, 8000)) - 4000,
                       int'($urandom_range(0, 8000)) - 4000, 1), 0, 180);
    run_phase(box_of(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768), 12, 70);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/obb_pkg.sv
rtl/core/obb_lane.sv
rtl/core/obb_merge.sv
rtl/core/obb2d_overlap_test.sv
bench/obb2d_overlap_test_tb.sv
